// File: rtl/pirp_pkg.sv
package pirp_pkg;

    // default number of polygon sides the pipeline is built for
    localparam int MAX_SIDES_DEF = 16;

    // Q16.16 half unit: apex height and y limit
    localparam logic signed [31:0] Y_LIMIT = 32'sd32768;
    // 0.00001 in units of 2^-34
    localparam logic signed [64:0] EPS_Q34 = 65'sd171798;

    localparam int ROW_W  = 48;
    localparam int DATA_W = 48;
    localparam int IDX_W  = 3;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_ROW_X    = 3'd0,
        REG_ROW_Y    = 3'd1,
        REG_ROW_Z    = 3'd2,
        REG_OFFSET_X = 3'd3,
        REG_OFFSET_Y = 3'd4,
        REG_OFFSET_Z = 3'd5,
        REG_SIDES    = 3'd6,
        REG_ROT_STEP = 3'd7
    } reg_idx_t;

    // state carried along the vertex/edge pipeline
    typedef struct packed {
        logic               valid;
        logic               early;      // result already known (y reject or apex)
        logic               early_res;
        logic               in_ok;      // no edge has failed so far
        logic signed [32:0] q_x;        // point x, z in 2^-17 units
        logic signed [32:0] q_z;
        logic signed [31:0] rad;        // first vertex z
        logic signed [31:0] last_x;     // vertex n-1, for the closing edge
        logic signed [31:0] last_z;
        logic signed [31:0] prev_x;
        logic signed [31:0] prev_z;
        logic signed [31:0] cur_x;
        logic signed [31:0] cur_z;
    } carry_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [47:0] mul16x32(input logic signed [15:0] a,
                                                    input logic signed [31:0] b);
        logic signed [47:0] a_w;
        logic signed [47:0] b_w;
        a_w = 48'(a);
        b_w = 48'(b);
        return a_w * b_w;
    endfunction

    function automatic logic signed [63:0] mul32x32(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [63:0] a_w;
        logic signed [63:0] b_w;
        a_w = 64'(a);
        b_w = 64'(b);
        return a_w * b_w;
    endfunction

endpackage

// File: rtl/pirp_step.sv
// One polygon step: rotates the current vertex to the next one and checks the
// edge from the previous vertex to the current one. Three register stages.
module pirp_step #(
    parameter int MAX_SIDES = pirp_pkg::MAX_SIDES_DEF,
    parameter int K         = 1,
    parameter bit CLOSE     = 1'b0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [15:0]                   rot_c,
    input  logic signed [15:0]                   rot_s,
    input  logic [$clog2(MAX_SIDES+1)-1:0]       sides,
    input  pirp_pkg::carry_t                     carry_in,
    output pirp_pkg::carry_t                     carry_out
);
    import pirp_pkg::*;

    // stage 1: rotation products and edge vectors
    carry_t             c1_reg;
    logic signed [47:0] pcx_reg, psz_reg, psx_reg, pcz_reg;
    logic signed [31:0] ax_reg, az_reg, bx_reg, bz_reg;

    // stage 2: next vertex and cross product terms
    carry_t             c2_reg;
    logic signed [31:0] nx_reg, nz_reg;
    logic signed [63:0] m1_reg, m2_reg;

    // stage 3: edge verdict and vertex shift
    carry_t             out_reg;
    carry_t             out_next;

    logic signed [33:0] dax, daz, dbx, dbz;
    logic signed [48:0] sum_x, sum_z;
    logic signed [34:0] rnd_x, rnd_z;
    logic signed [64:0] lambda;
    logic               edge_on;
    logic               take_last;

    assign dax = 34'(carry_in.prev_x) - 34'(carry_in.q_x);
    assign daz = 34'(carry_in.prev_z) - 34'(carry_in.q_z);
    assign dbx = 34'(carry_in.cur_x) - 34'(carry_in.q_x);
    assign dbz = 34'(carry_in.cur_z) - 34'(carry_in.q_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
        end
        else
        begin
            c1_reg <= carry_in;
        end
    end

    always_ff @(posedge clk)
    begin
        pcx_reg <= mul16x32(rot_c, carry_in.cur_x);
        psz_reg <= mul16x32(rot_s, carry_in.cur_z);
        psx_reg <= mul16x32(rot_s, carry_in.cur_x);
        pcz_reg <= mul16x32(rot_c, carry_in.cur_z);
        ax_reg  <= sat32(66'(dax));
        az_reg  <= sat32(66'(daz));
        bx_reg  <= sat32(66'(dbx));
        bz_reg  <= sat32(66'(dbz));
    end

    // round half up, floor shift, saturate
    assign sum_x = 49'(pcx_reg) - 49'(psz_reg) + 49'sd8192;
    assign sum_z = 49'(psx_reg) + 49'(pcz_reg) + 49'sd8192;
    assign rnd_x = 35'(sum_x >>> 14);
    assign rnd_z = 35'(sum_z >>> 14);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_reg <= '0;
        end
        else
        begin
            c2_reg <= c1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        nx_reg <= sat32(66'(rnd_x));
        nz_reg <= sat32(66'(rnd_z));
        m1_reg <= mul32x32(ax_reg, bz_reg);
        m2_reg <= mul32x32(az_reg, bx_reg);
    end

    // edge k-2 exists for 2 <= k <= n; the closing edge always counts
    assign edge_on   = CLOSE || ((K >= 2) && (K <= int'(sides)));
    assign take_last = !CLOSE && (K == int'(sides));
    assign lambda    = 65'(m1_reg) - 65'(m2_reg);

    always_comb
    begin
        out_next        = c2_reg;
        out_next.prev_x = c2_reg.cur_x;
        out_next.prev_z = c2_reg.cur_z;
        out_next.cur_x  = nx_reg;
        out_next.cur_z  = nz_reg;
        if (take_last)
        begin
            out_next.last_x = c2_reg.cur_x;
            out_next.last_z = c2_reg.cur_z;
        end
        if (edge_on && (lambda < -EPS_Q34))
        begin
            out_next.in_ok = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else
        begin
            out_reg <= out_next;
        end
    end

    assign carry_out = out_reg;

endmodule

// File: rtl/point_in_regular_pyramid.sv
// Point-in-regular-pyramid classifier. Takes one Q16.16 point per clock on
// start and returns inside_res with a one-cycle done strobe. The vertex chain
// has a step for each of the MAX_SIDES vertices, whatever the configured side
// count: each polygon vertex, plus the closing edge, takes three stages
// (multiply, round and cross-product multiply, edge compare), after three
// stages of affine transform and y test. busy is always low and results
// cannot be held off, so the receiver must take every done beat.
// Configuration writes take effect at once and belong only to periods with
// no point in flight.
module point_in_regular_pyramid #(
    parameter int MAX_SIDES = pirp_pkg::MAX_SIDES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [31:0]          pos_x,
    input  logic signed [31:0]          pos_y,
    input  logic signed [31:0]          pos_z,
    output logic                        done,
    output logic                        inside_res,
    input  logic                        wr_en,
    input  logic [pirp_pkg::IDX_W-1:0]  wr_index,
    input  logic [pirp_pkg::DATA_W-1:0] wr_data
);
    import pirp_pkg::*;

    localparam int NW = $clog2(MAX_SIDES + 1);

    // configuration registers
    logic [ROW_W-1:0]   row_x_reg, row_y_reg, row_z_reg;
    logic signed [31:0] off_x_reg, off_y_reg, off_z_reg;
    logic [4:0]         sides_reg;
    logic [31:0]        rot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg <= 48'h4000_0000_0000;
            row_y_reg <= 48'h0000_4000_0000;
            row_z_reg <= 48'h0000_0000_4000;
            off_x_reg <= '0;
            off_y_reg <= '0;
            off_z_reg <= '0;
            sides_reg <= 5'd4;
            rot_reg   <= 32'h0000_4000;
        end
        else if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_ROW_X:    row_x_reg <= wr_data;
                REG_ROW_Y:    row_y_reg <= wr_data;
                REG_ROW_Z:    row_z_reg <= wr_data;
                REG_OFFSET_X: off_x_reg <= wr_data[31:0];
                REG_OFFSET_Y: off_y_reg <= wr_data[31:0];
                REG_OFFSET_Z: off_z_reg <= wr_data[31:0];
                REG_SIDES:    sides_reg <= wr_data[4:0];
                REG_ROT_STEP: rot_reg   <= wr_data[31:0];
                default: ;
            endcase
        end
    end

    // clamped side count and rotation coefficients
    logic [NW-1:0]      sides;
    logic signed [15:0] rot_c, rot_s;

    always_comb
    begin
        if (sides_reg < 5'd3)
            sides = NW'(3);
        else if (int'(sides_reg) > MAX_SIDES)
            sides = NW'(MAX_SIDES);
        else
            sides = NW'(sides_reg);
    end

    assign rot_c = rot_reg[31:16];
    assign rot_s = rot_reg[15:0];

    // stage f1: matrix products
    logic               f1_valid_reg;
    logic signed [47:0] px_reg [3];
    logic signed [47:0] py_reg [3];
    logic signed [47:0] pz_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else
            f1_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        px_reg[0] <= mul16x32(row_x_reg[47:32], pos_x);
        py_reg[0] <= mul16x32(row_x_reg[31:16], pos_y);
        pz_reg[0] <= mul16x32(row_x_reg[15:0],  pos_z);
        px_reg[1] <= mul16x32(row_y_reg[47:32], pos_x);
        py_reg[1] <= mul16x32(row_y_reg[31:16], pos_y);
        pz_reg[1] <= mul16x32(row_y_reg[15:0],  pos_z);
        px_reg[2] <= mul16x32(row_z_reg[47:32], pos_x);
        py_reg[2] <= mul16x32(row_z_reg[31:16], pos_y);
        pz_reg[2] <= mul16x32(row_z_reg[15:0],  pos_z);
    end

    // stage f2: sum with offset, floor shift, saturate
    logic               f2_valid_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic signed [49:0] acc [3];
    logic signed [31:0] offs [3];

    assign offs[0] = off_x_reg;
    assign offs[1] = off_y_reg;
    assign offs[2] = off_z_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = 50'(px_reg[i]) + 50'(py_reg[i]) + 50'(pz_reg[i])
                   + (50'(offs[i]) <<< 14);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f2_valid_reg <= 1'b0;
        else
            f2_valid_reg <= f1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        cx_reg <= sat32(66'(acc[0] >>> 14));
        cy_reg <= sat32(66'(acc[1] >>> 14));
        cz_reg <= sat32(66'(acc[2] >>> 14));
    end

    // stage f3: y window, apex, first vertex
    carry_t f3_reg;
    carry_t f3_next;
    logic   reject;
    logic   apex;

    assign reject = (cy_reg > Y_LIMIT) || (cy_reg < -Y_LIMIT);
    assign apex   = (cy_reg == Y_LIMIT);

    always_comb
    begin
        f3_next           = '0;
        f3_next.valid     = f2_valid_reg;
        f3_next.early     = reject || apex;
        f3_next.early_res = apex && (cx_reg == '0) && (cz_reg == '0);
        f3_next.in_ok     = 1'b1;
        f3_next.q_x       = 33'(cx_reg) <<< 1;
        f3_next.q_z       = 33'(cz_reg) <<< 1;
        f3_next.rad       = Y_LIMIT - cy_reg;
        f3_next.cur_z     = Y_LIMIT - cy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f3_reg <= '0;
        else
            f3_reg <= f3_next;
    end

    // vertex chain, one step per vertex
    carry_t chain [MAX_SIDES + 1];
    carry_t close_in;
    carry_t close_out;

    assign chain[0] = f3_reg;

    for (genvar k = 1; k <= MAX_SIDES; k++)
    begin : g_step
        pirp_step #(
            .MAX_SIDES (MAX_SIDES),
            .K         (k),
            .CLOSE     (1'b0)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .rot_c     (rot_c),
            .rot_s     (rot_s),
            .sides     (sides),
            .carry_in  (chain[k-1]),
            .carry_out (chain[k])
        );
    end

    // closing edge: vertex n-1 back to the first vertex
    always_comb
    begin
        close_in        = chain[MAX_SIDES];
        close_in.prev_x = chain[MAX_SIDES].last_x;
        close_in.prev_z = chain[MAX_SIDES].last_z;
        close_in.cur_x  = '0;
        close_in.cur_z  = chain[MAX_SIDES].rad;
    end

    pirp_step #(
        .MAX_SIDES (MAX_SIDES),
        .K         (MAX_SIDES + 1),
        .CLOSE     (1'b1)
    ) u_close (
        .clk       (clk),
        .rst_n     (rst_n),
        .rot_c     (rot_c),
        .rot_s     (rot_s),
        .sides     (sides),
        .carry_in  (close_in),
        .carry_out (close_out)
    );

    // result beat
    assign busy       = 1'b0;
    assign done       = close_out.valid;
    assign inside_res = close_out.early ? close_out.early_res : close_out.in_ok;

endmodule

// File: rtl/pirp_checker.sv
// Port-level checks for the pyramid classifier.
module pirp_checker #(
    parameter int MAX_SIDES = pirp_pkg::MAX_SIDES_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    localparam int LAT = 3 * MAX_SIDES + 6;

    // fully pipelined: never refuses a point
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // every accepted point gives a result beat after the fixed latency
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result beat missing");

    // no result beat without a point accepted the same latency earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("unexpected result beat");

endmodule

bind point_in_regular_pyramid pirp_checker #(.MAX_SIDES(MAX_SIDES)) u_pirp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

// File: tb/tb_point_in_regular_pyramid.sv
module tb_point_in_regular_pyramid;
    import pirp_pkg::*;

    localparam int LATENCY   = 3 * MAX_SIDES_DEF + 6;
    localparam int WDOG_MAX  = 4000;
    localparam int N_RANDOM  = 1830;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        done;
    logic        inside_res;
    logic        wr_en;
    logic [IDX_W-1:0]  wr_index;
    logic [DATA_W-1:0] wr_data;

    point_in_regular_pyramid dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .done       (done),
        .inside_res (inside_res),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    // shadow copy of the configuration registers
    logic [47:0] row_x_q, row_y_q, row_z_q;
    logic [31:0] off_x_q, off_y_q, off_z_q;
    logic [4:0]  sides_q;
    logic [31:0] step_q;

    logic        inside_exp_q[$];
    int          n_fail;
    int          n_beats;
    int          n_results;
    int          n_inside;
    int          idle_cycles;
    int          send_idle_pct;

    // directed table: point and, where obvious, the expected flag
    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        bit          has_exp;
        bit          exp_val;
    } point_row_t;

    point_row_t dir_tbl[$];

    initial begin
        clk = 1'b0;
    end
    always #5 clk = ~clk;

    // clamp to the signed 32-bit range; map_axis floor-shifts its Q.30 sum to Q16.16 first
    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] map_axis(input logic [47:0] row,
                                                    input logic [31:0] off,
                                                    input logic signed [31:0] px,
                                                    input logic signed [31:0] py,
                                                    input logic signed [31:0] pz);
        logic signed [63:0] acc;
        acc = 64'(signed'(row[47:32])) * 64'(px)
            + 64'(signed'(row[31:16])) * 64'(py)
            + 64'(signed'(row[15:0]))  * 64'(pz)
            + 64'(signed'(off)) * 64'sd16384;
        return clamp32(acc >>> 14);
    endfunction

    // expected inside flag for one point under the current shadow config
    function automatic bit pyramid_contains(input logic signed [31:0] px,
                                            input logic signed [31:0] py,
                                            input logic signed [31:0] pz);
        logic signed [31:0] cx, cy, cz;
        logic signed [63:0] c, s, r, qx, qz, ax, az, bx, bz, lam;
        logic signed [63:0] vx[MAX_SIDES_DEF];
        logic signed [63:0] vz[MAX_SIDES_DEF];
        int  n, j;
        cx = map_axis(row_x_q, off_x_q, px, py, pz);
        cy = map_axis(row_y_q, off_y_q, px, py, pz);
        cz = map_axis(row_z_q, off_z_q, px, py, pz);
        if (cy > 32768 || cy < -32768)
            return 1'b0;
        r = 64'sd32768 - 64'(cy);
        if (r == 0)
            return (cx == 0 && cz == 0);
        n = sides_q;
        if (n < 3)
            n = 3;
        if (n > MAX_SIDES_DEF)
            n = MAX_SIDES_DEF;
        c = 64'(signed'(step_q[31:16]));
        s = 64'(signed'(step_q[15:0]));
        vx[0] = 0;
        vz[0] = r;
        for (int i = 1; i < n; i++) begin
            vx[i] = 64'(clamp32((c * vx[i-1] - s * vz[i-1] + 8192) >>> 14));
            vz[i] = 64'(clamp32((s * vx[i-1] + c * vz[i-1] + 8192) >>> 14));
        end
        qx = 64'(cx) * 2;
        qz = 64'(cz) * 2;
        for (int i = 0; i < n; i++) begin
            j = (i + 1 == n) ? 0 : i + 1;
            ax = 64'(clamp32(vx[i] - qx));
            az = 64'(clamp32(vz[i] - qz));
            bx = 64'(clamp32(vx[j] - qx));
            bz = 64'(clamp32(vz[j] - qz));
            lam = ax * bz - az * bx;
            if (lam < -64'sd171798)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // result checker: done beats cannot be held off
    always @(posedge clk) begin
        if (rst_n && done) begin
            n_results++;
            if (inside_res)
                n_inside++;
            if (inside_exp_q.size() == 0) begin
                $error("inside_res: unexpected result %0b", inside_res);
                n_fail++;
            end
            else begin
                if (inside_res !== inside_exp_q[0]) begin
                    $error("inside_res: expected %0b actual %0b",
                           inside_exp_q[0], inside_res);
                    n_fail++;
                end
                void'(inside_exp_q.pop_front());
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("[point_in_regular_pyramid] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [47:0] val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
        wr_en    <= 1'b0;
        case (idx)
            REG_ROW_X:    row_x_q = val;
            REG_ROW_Y:    row_y_q = val;
            REG_ROW_Z:    row_z_q = val;
            REG_OFFSET_X: off_x_q = val[31:0];
            REG_OFFSET_Y: off_y_q = val[31:0];
            REG_OFFSET_Z: off_z_q = val[31:0];
            REG_SIDES:    sides_q = val[4:0];
            REG_ROT_STEP: step_q  = val[31:0];
            default: ;
        endcase
    endtask

    // wait for all results, then let the pipeline drain
    task automatic drain_pipe();
        while (inside_exp_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // one point beat; called at a falling edge, returns at a falling edge
    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input bit has_exp,
                              input bit exp_val);
        bit pred;
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pred = pyramid_contains(x, y, z);
        if (has_exp && pred != exp_val) begin
            $error("inside_res: table expects %0b, predictor gives %0b", exp_val, pred);
            n_fail++;
        end
        inside_exp_q = {inside_exp_q, pred};
        n_beats++;
        @(negedge clk);
    endtask

    task automatic end_burst();
        start <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(5))
            0: return 16'h4000;
            1: return 16'hc000;
            2: return 16'h0000;
            3: return 16'h7fff;
            4: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            3: return 32'($urandom_range(65536)) - 32'd32768;
            default: return 32'(signed'($urandom_range(131072)) - 65536);
        endcase
    endfunction

    // random config set; mostly sane shapes so points land near the pyramid
    task automatic random_config(input int sides);
        int   ang_c, ang_s;
        real  a;
        a = 6.283185 / sides;
        ang_c = $rtoi($cos(a) * 16384.0);
        ang_s = $rtoi($sin(a) * 16384.0);
        if ($urandom_range(3) == 0) begin
            write_reg(REG_ROW_X, {rand_coef(), rand_coef(), rand_coef()});
            write_reg(REG_ROW_Y, {rand_coef(), rand_coef(), rand_coef()});
            write_reg(REG_ROW_Z, {rand_coef(), rand_coef(), rand_coef()});
            write_reg(REG_ROT_STEP, 48'($urandom));
        end
        else begin
            write_reg(REG_ROW_X, {16'h4000, 16'($urandom_range(255)), 16'h0000});
            write_reg(REG_ROW_Y, {16'h0000, 16'h4000, 16'h0000});
            write_reg(REG_ROW_Z, {16'h0000, 16'h0000, 16'h4000 - 16'($urandom_range(7))});
            write_reg(REG_ROT_STEP, {16'h0000, 16'(ang_c), 16'(ang_s)});
        end
        write_reg(REG_OFFSET_X, 48'(32'(signed'($urandom_range(8192)) - 4096)));
        write_reg(REG_OFFSET_Y, 48'(32'(signed'($urandom_range(8192)) - 4096)));
        write_reg(REG_OFFSET_Z, 48'(32'(signed'($urandom_range(8192)) - 4096)));
        write_reg(REG_SIDES, 48'(sides));
    endtask

    initial begin
        logic [31:0] rx, ry, rz;
        int          sides;
        int          phase_len;
        rst_n         = 1'b0;
        start         = 1'b0;
        pos_x         = '0;
        pos_y         = '0;
        pos_z         = '0;
        wr_en         = 1'b0;
        wr_index      = '0;
        wr_data       = '0;
        n_fail        = 0;
        n_beats       = 0;
        n_results     = 0;
        n_inside      = 0;
        idle_cycles   = 0;
        send_idle_pct = 0;
        row_x_q = 48'h4000_0000_0000;
        row_y_q = 48'h0000_4000_0000;
        row_z_q = 48'h0000_0000_4000;
        off_x_q = '0;
        off_y_q = '0;
        off_z_q = '0;
        sides_q = 5'd4;
        step_q  = 32'h0000_4000;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed points under reset config (square base, identity map)
        dir_tbl = '{
            '{32'h0000_0000, 32'h0000_8000, 32'h0000_0000, 1'b1, 1'b1},  // apex on axis
            '{32'h0000_0001, 32'h0000_8000, 32'h0000_0000, 1'b1, 1'b0},  // apex off axis
            '{32'h0000_0000, 32'h0000_8000, 32'hffff_ffff, 1'b1, 1'b0},
            '{32'h0000_0000, 32'h0000_8001, 32'h0000_0000, 1'b1, 1'b0},  // above top
            '{32'h0000_0000, 32'hffff_7fff, 32'h0000_0000, 1'b1, 1'b0},  // below base
            '{32'h0000_0000, 32'hffff_8000, 32'h0000_0000, 1'b1, 1'b1},  // base center
            '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1},
            // far corner: all edge vectors clamp alike, cross products vanish
            '{32'h7fff_ffff, 32'h0000_0000, 32'h7fff_ffff, 1'b1, 1'b1},
            '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0},
            '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b0},
            '{32'h0000_0000, 32'hffff_8000, 32'h0000_8000, 1'b0, 1'b0},  // base vertex
            '{32'h0000_4000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
            '{32'h0000_2000, 32'h0000_0000, 32'h0000_2000, 1'b0, 1'b0},
            '{32'hffff_c000, 32'h0000_4000, 32'h0000_0000, 1'b0, 1'b0},
            '{32'h0000_0000, 32'hffff_ffff, 32'h0000_4001, 1'b0, 1'b0}
        };
        foreach (dir_tbl[i])
            send_point(dir_tbl[i].x, dir_tbl[i].y, dir_tbl[i].z,
                       dir_tbl[i].has_exp, dir_tbl[i].exp_val);
        end_burst();
        drain_pipe();

        // side count extremes, out-of-range values and a degenerate step
        write_reg(REG_SIDES, 48'd0);
        send_point(32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        end_burst();
        drain_pipe();
        write_reg(REG_SIDES, 48'd31);
        write_reg(REG_ROT_STEP, 48'h0000_7fff_7fff);
        send_point(32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        send_point(32'h7fff_ffff, 32'hffff_8000, 32'h8000_0000, 1'b0, 1'b0);
        end_burst();
        drain_pipe();

        // random phases: sender idle 32%, then 74%, then none
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 74 : 0;
            for (int k = 0; k < 6; k++) begin
                case (k)
                    0: sides = 3;
                    1: sides = 16;
                    default: sides = $urandom_range(3, 16);
                endcase
                random_config(sides);
                phase_len = N_RANDOM / 18;
                for (int it = 0; it < phase_len; it++) begin
                    rx = rand_pos();
                    ry = rand_pos();
                    rz = rand_pos();
                    if ($urandom_range(15) == 0)
                        ry = 32'h0000_8000;
                    send_point(rx, ry, rz, 1'b0, 1'b0);
                    // every so often stop sending until the pipe is empty
                    if ($urandom_range(199) == 0) begin
                        end_burst();
                        while (inside_exp_q.size() != 0)
                            @(negedge clk);
                    end
                end
                end_burst();
                drain_pipe();
            end
        end

        $display("Sent %0d points over 18 random configs plus directed cases;",
                 n_beats);
        $display("%0d results checked, %0d inside.", n_results, n_inside);
        if (n_fail == 0)
            $display("[point_in_regular_pyramid] OK");
        else
            $display("[point_in_regular_pyramid] ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/pirp_pkg.sv
rtl/pirp_step.sv
rtl/point_in_regular_pyramid.sv
rtl/pirp_checker.sv
tb/tb_point_in_regular_pyramid.sv
